### hdl/msk_pkg.sv
// Shared types and constants for the Morse symbol keyer.
// Used by the keyer top level and its port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msk_pkg;

	// default sizing for the code table
	localparam int SYMBOL_COUNT_DEF = 256;
	localparam int MAX_ELEMENTS_DEF = 8;

	// field widths
	localparam int SYM_W  = 8;
	localparam int LEN_W  = 4;
	localparam int PAT_W  = 8;
	localparam int DOT_W  = 16;
	localparam int DUR_W  = 18;
	localparam int ENTRY_W = LEN_W + PAT_W;

	// request kinds
	localparam logic KIND_DEFINE = 1'b0;
	localparam logic KIND_PLAY   = 1'b1;

	// word space symbol
	localparam logic [SYM_W-1:0] WORD_SPACE = 8'd32;

	// dot length after reset
	localparam logic [DOT_W-1:0] DOT_LENGTH_RESET = 16'd100;

	// multiplier codes for the shared duration adder
	localparam logic [1:0] MUL_ZERO  = 2'd0;
	localparam logic [1:0] MUL_ONE   = 2'd1;
	localparam logic [1:0] MUL_THREE = 2'd2;
	localparam logic [1:0] MUL_FOUR  = 2'd3;

	// one code table entry
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [PAT_W-1:0] pattern;
	} msk_entry_t;

endpackage

`default_nettype wire

### hdl/msk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module msk_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/morse_symbol_keyer_top.sv
// Morse symbol keyer: code table in RAM, a small sequencer and one shared duration adder.
// Depends on msk_pkg and msk_ram.
//
//   channel   handshake                 payload
//   request   start, busy (accept: start & !busy)
//                                       kind, symbol, code_length, code_pattern
//   result    result_strobe (1 cycle)   tone_on, duration_ticks, last_segment, no_code
//   config    cfg_we                    cfg_wdata (dot_length)
//
// A define request leaves busy low; the next request may follow at once.
// A play request goes to FETCH, then TONE and GAP per code element (MAX_ELEMENTS at most);
// a word space or a symbol without code ends in FETCH; one result leaves per cycle after the table read.
// Every duration comes from the one shared adder, one segment per cycle.
// Reset clears the table valid bits, so every symbol reads as having no code.
// The receiver cannot stall; results are never held.
`timescale 1ns / 1ps
`default_nettype none

module morse_symbol_keyer_top import msk_pkg::*; #(
	parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              kind,
	input  wire logic [SYM_W-1:0]  symbol,
	input  wire logic [LEN_W-1:0]  code_length,
	input  wire logic [PAT_W-1:0]  code_pattern,
	input  wire logic              cfg_we,
	input  wire logic [DOT_W-1:0]  cfg_wdata,
	output logic                   result_strobe,
	output logic                   tone_on,
	output logic      [DUR_W-1:0]  duration_ticks,
	output logic                   last_segment,
	output logic                   no_code
);

	localparam int ADDR_W = $clog2(SYMBOL_COUNT);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ELEMENTS);
	localparam logic [SYM_W:0]   SYM_LIMIT = (SYM_W+1)'(SYMBOL_COUNT);

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FETCH = 2'd1;
	localparam logic [1:0] ST_TONE  = 2'd2;
	localparam logic [1:0] ST_GAP   = 2'd3;

	logic [1:0]        state_q;
	logic [DOT_W-1:0]  dot_length_q;
	logic [SYMBOL_COUNT-1:0] valid_q;
	logic              space_q;
	logic              hit_q;
	logic [LEN_W-1:0]  rem_q;
	logic [PAT_W-1:0]  pat_q;

	logic              accept;
	logic              sym_in_range;
	logic [ADDR_W-1:0] addr;
	logic              def_we;
	logic [LEN_W-1:0]  def_len;
	msk_entry_t        wr_entry;
	msk_entry_t        rd_entry;
	logic [ENTRY_W-1:0] rd_data;
	logic [LEN_W-1:0]  fetch_len;

	logic              emit;
	logic              seg_tone;
	logic [1:0]        seg_mul;
	logic              seg_last;
	logic              seg_no_code;
	logic [DUR_W-1:0]  add_a;
	logic [DUR_W-1:0]  add_b;
	logic [DUR_W-1:0]  seg_dur;

	assign busy         = (state_q != ST_IDLE);
	assign accept       = start & ~busy;
	assign sym_in_range = ({1'b0, symbol} < SYM_LIMIT);
	assign addr         = symbol[ADDR_W-1:0];

	// saturate the code length on define
	assign def_len  = (code_length > MAX_LEN) ? MAX_LEN : code_length;
	assign def_we   = accept & (kind == KIND_DEFINE) & sym_in_range;
	assign wr_entry = '{len: def_len, pattern: code_pattern};

	msk_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SYMBOL_COUNT)
	) u_table (
		.clk   (clk),
		.we    (def_we),
		.waddr (addr),
		.wdata (wr_entry),
		.re    (accept & (kind == KIND_PLAY)),
		.raddr (addr),
		.rdata (rd_data)
	);

	assign rd_entry  = msk_entry_t'(rd_data);
	assign fetch_len = hit_q ? rd_entry.len : '0;

	// hold the dot length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_length_q <= DOT_LENGTH_RESET;
		end else if (cfg_we) begin
			dot_length_q <= cfg_wdata;
		end
	end

	// mark table entries as written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (def_we) begin
			valid_q[addr] <= 1'b1;
		end
	end

	// pick the segment for the current state
	always_comb begin
		emit        = 1'b0;
		seg_tone    = 1'b0;
		seg_mul     = MUL_ZERO;
		seg_last    = 1'b0;
		seg_no_code = 1'b0;
		case (state_q)
			ST_FETCH: begin
				if (space_q) begin
					emit     = 1'b1;
					seg_mul  = MUL_FOUR;
					seg_last = 1'b1;
				end else if (fetch_len == '0) begin
					emit        = 1'b1;
					seg_last    = 1'b1;
					seg_no_code = 1'b1;
				end
			end
			ST_TONE: begin
				emit     = 1'b1;
				seg_tone = 1'b1;
				seg_mul  = pat_q[0] ? MUL_ONE : MUL_THREE;
			end
			ST_GAP: begin
				emit     = 1'b1;
				seg_last = (rem_q == LEN_W'(1));
				seg_mul  = seg_last ? MUL_THREE : MUL_ONE;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// shared duration adder: x1 = d + 0, x3 = d + 2d, x4 = 0 + 4d
	always_comb begin
		case (seg_mul)
			MUL_ONE: begin
				add_a = DUR_W'(dot_length_q);
				add_b = '0;
			end
			MUL_THREE: begin
				add_a = DUR_W'(dot_length_q);
				add_b = {1'b0, dot_length_q, 1'b0};
			end
			MUL_FOUR: begin
				add_a = '0;
				add_b = {dot_length_q, 2'b00};
			end
			default: begin
				add_a = '0;
				add_b = '0;
			end
		endcase
		seg_dur = add_a + add_b;
	end

	// advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (kind == KIND_PLAY)) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					if (space_q || (fetch_len == '0)) begin
						state_q <= ST_IDLE;
					end else begin
						rem_q   <= fetch_len;
						state_q <= ST_TONE;
					end
				end
				ST_TONE: begin
					state_q <= ST_GAP;
				end
				ST_GAP: begin
					if (rem_q == LEN_W'(1)) begin
						state_q <= ST_IDLE;
					end else begin
						rem_q   <= rem_q - LEN_W'(1);
						state_q <= ST_TONE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// latch play request flags and shift the element pattern
	always_ff @(posedge clk) begin
		if (accept) begin
			space_q <= (symbol == WORD_SPACE);
			hit_q   <= sym_in_range & valid_q[addr];
		end
		if (state_q == ST_FETCH) begin
			pat_q <= rd_entry.pattern;
		end else if (state_q == ST_GAP) begin
			pat_q <= {1'b0, pat_q[PAT_W-1:1]};
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= emit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			tone_on        <= seg_tone;
			duration_ticks <= seg_dur;
			last_segment   <= seg_last;
			no_code        <= seg_no_code;
		end
	end

endmodule

`default_nettype wire

### hdl/msk_chk.sv
// Port checker for the Morse symbol keyer, bound to the top level.
// Depends on msk_pkg and morse_symbol_keyer_top.
`timescale 1ns / 1ps
`default_nettype none

module msk_chk import msk_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire logic             kind,
	input wire logic             result_strobe,
	input wire logic             tone_on,
	input wire logic [DUR_W-1:0] duration_ticks,
	input wire logic             last_segment,
	input wire logic             no_code
);

	// a result only follows a cycle of work
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result without a busy cycle before it");

	// a play request holds the block busy
	a_play_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == KIND_PLAY)) |=> busy)
		else $error("play request did not raise busy");

	// every tone is followed at once by its silence
	a_tone_then_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && tone_on) |=> (result_strobe && !tone_on))
		else $error("tone not followed by a silence");

	// a missing code gives one empty final result
	a_no_code_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && no_code) |->
			(last_segment && !tone_on && (duration_ticks == '0)))
		else $error("malformed no-code result");

endmodule

bind morse_symbol_keyer_top msk_chk u_msk_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.kind           (kind),
	.result_strobe  (result_strobe),
	.tone_on        (tone_on),
	.duration_ticks (duration_ticks),
	.last_segment   (last_segment),
	.no_code        (no_code)
);

`default_nettype wire
